### rtl/core/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, codes and field widths of the running sample statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    localparam int KIND_W = 2;
    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_CLEAR  = 2'd0;
    localparam kind_t KIND_SAMPLE = 2'd1;
    localparam kind_t KIND_FINAL  = 2'd2;

    localparam int IN_SAMPLE_W = 16;
    localparam int COUNT_OUT_W = 16;
    localparam int VAL_W       = 16;
    localparam int POWER_W     = 31;
    localparam int ROOT_OUT_W  = 16;

    localparam int RESULT_W  = COUNT_OUT_W + 3 * VAL_W + 2 * POWER_W + 2 * ROOT_OUT_W;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam logic DIV_SUM     = 1'b0;
    localparam logic DIV_SQUARES = 1'b1;
    localparam logic ROOT_MS     = 1'b0;
    localparam logic ROOT_VAR    = 1'b1;

    typedef struct packed {
        logic                   ready_res;
        logic                   saturated;
        logic [COUNT_OUT_W-1:0] sample_count;
        logic [VAL_W-1:0]       minimum;
        logic [VAL_W-1:0]       maximum;
        logic [VAL_W-1:0]       mean;
        logic [POWER_W-1:0]     mean_square;
        logic [POWER_W-1:0]     variance;
        logic [ROOT_OUT_W-1:0]  rms;
        logic [ROOT_OUT_W-1:0]  std_dev;
    } result_t;

    typedef struct packed {
        logic div_init;
        logic div_sel;
        logic div_step;
        logic mean_load;
        logic ms_load;
        logic msq_load;
        logic var_load;
        logic root_init;
        logic root_sel;
        logic root_step;
        logic rms_load;
        logic sd_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic count_ge2;
        logic out_free;
    } status_t;

    // width of the sum of squares, held to 64 bits
    function automatic int sq_width(input int s, input int c);
        int full;
        full = 2 * s - 2 + c;
        return (full > 64) ? 64 : full;
    endfunction

endpackage

`default_nettype wire

### rtl/core/running_sample_statistics.sv
// ----------------------------------------------------------------------------
// running_sample_statistics
// Running minimum, maximum, mean, mean square, variance, rms and standard
// deviation of a stream of signed samples.
//
// The slave channel takes one word per item: s_tuser carries the kind (clear
// with seed, add sample, finalize) and s_tdata the sample. Clear and sample
// words are taken at one per cycle while no finalize runs; they update the
// accumulators at once, the square entering the sum of squares next cycle.
// A finalize word with at least two samples held runs a one-bit-per-cycle
// divider twice (DIV_STEPS = min(2*SAMPLE_BITS-2+COUNT_BITS, 64) steps each)
// and a two-bit-per-cycle square root twice (SAMPLE_BITS steps each); the
// result word appears on the master channel once all of these are done, with
// s_tready low meanwhile. With fewer than two samples the controller skips
// the divisions and roots and goes straight to publishing the result.
// The result sits in an output register; clear and sample words are still
// taken while it waits, but a further finalize holds in its last step until
// m_tready frees the register. Reset zeroes all accumulators and flags and
// drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire [rss_pkg::IN_SAMPLE_W-1:0]      s_tdata,   // sample
    input  wire [rss_pkg::KIND_W-1:0]           s_tuser,   // kind
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // sample_count, minimum, maximum, mean, mean_square, variance, rms, std_dev
    output logic [rss_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [rss_pkg::M_TUSER_W-1:0]       m_tuser    // ready_res, saturated
);

    localparam int DIV_STEPS  = rss_pkg::sq_width(SAMPLE_BITS, COUNT_BITS);
    localparam int ROOT_STEPS = SAMPLE_BITS;
    localparam int PAD_W      = rss_pkg::M_TDATA_W - rss_pkg::RESULT_W;

    rss_pkg::cmd_t     cmd;
    rss_pkg::status_t  status;
    rss_pkg::result_t  res;
    logic              in_fire;

    assign in_fire = s_tvalid && s_tready;

    rss_ctrl #(
        .DIV_STEPS  (DIV_STEPS),
        .ROOT_STEPS (ROOT_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    rss_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_kind   (s_tuser),
        .in_sample (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .result    (res)
    );

    assign m_tdata = {PAD_W'(0), res.std_dev, res.rms, res.variance, res.mean_square,
                      res.mean, res.maximum, res.minimum, res.sample_count};
    assign m_tuser = {res.saturated, res.ready_res};

    a_not_ready_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.ready_res |->
            res.mean == '0 && res.mean_square == '0 && res.variance == '0 &&
            res.rms == '0 && res.std_dev == '0)
        else $error("derived figures set on a not-ready result");

    a_var_below_ms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.ready_res && SAMPLE_BITS <= 16 |-> res.variance <= res.mean_square)
        else $error("variance exceeds mean square");

    a_final_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == rss_pkg::KIND_FINAL |=> !s_tready)
        else $error("input taken while a finalize is in progress");

    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready, 2))
        else $error("result word without a finalize pass");

endmodule

`default_nettype wire

### rtl/core/rss_ctrl.sv
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer for the finalize pass: two divisions, the mean product, the
// variance and two square roots, then the hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_ctrl #(
    parameter int DIV_STEPS  = 47,
    parameter int ROOT_STEPS = 16
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    in_valid,
    input  rss_pkg::kind_t         in_kind,
    input  rss_pkg::status_t       status,
    output logic                   in_ready,
    output rss_pkg::cmd_t          cmd
);

    localparam int MAX_STEPS = (DIV_STEPS > ROOT_STEPS) ? DIV_STEPS : ROOT_STEPS;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM_DIV,
        ST_SQ_DIV,
        ST_PRODUCT,
        ST_DIFF,
        ST_ROOT_MS,
        ST_ROOT_VAR,
        ST_PUBLISH
    } state_t;

    state_t             state_reg;
    rss_pkg::cmd_t      cmd_reg;
    logic [STEP_W-1:0]  cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmd_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            cmd_reg <= '0;
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid && in_kind == rss_pkg::KIND_FINAL) begin
                        if (status.count_ge2) begin
                            state_reg        <= ST_SUM_DIV;
                            cmd_reg.div_init <= 1'b1;
                            cmd_reg.div_sel  <= rss_pkg::DIV_SUM;
                            cnt_reg          <= STEP_W'(DIV_STEPS);
                        end else begin
                            state_reg <= ST_PUBLISH;
                        end
                    end
                end
                ST_SUM_DIV: begin
                    if (cnt_reg != '0) begin
                        cmd_reg.div_step <= 1'b1;
                        cnt_reg          <= cnt_reg - 1'b1;
                    end else begin
                        cmd_reg.mean_load <= 1'b1;
                        cmd_reg.div_init  <= 1'b1;
                        cmd_reg.div_sel   <= rss_pkg::DIV_SQUARES;
                        cnt_reg           <= STEP_W'(DIV_STEPS);
                        state_reg         <= ST_SQ_DIV;
                    end
                end
                ST_SQ_DIV: begin
                    if (cnt_reg != '0) begin
                        cmd_reg.div_step <= 1'b1;
                        cnt_reg          <= cnt_reg - 1'b1;
                    end else begin
                        cmd_reg.ms_load <= 1'b1;
                        state_reg       <= ST_PRODUCT;
                    end
                end
                ST_PRODUCT: begin
                    cmd_reg.msq_load <= 1'b1;
                    state_reg        <= ST_DIFF;
                end
                ST_DIFF: begin
                    cmd_reg.var_load  <= 1'b1;
                    cmd_reg.root_init <= 1'b1;
                    cmd_reg.root_sel  <= rss_pkg::ROOT_MS;
                    cnt_reg           <= STEP_W'(ROOT_STEPS);
                    state_reg         <= ST_ROOT_MS;
                end
                ST_ROOT_MS: begin
                    if (cnt_reg != '0) begin
                        cmd_reg.root_step <= 1'b1;
                        cnt_reg           <= cnt_reg - 1'b1;
                    end else begin
                        cmd_reg.rms_load  <= 1'b1;
                        cmd_reg.root_init <= 1'b1;
                        cmd_reg.root_sel  <= rss_pkg::ROOT_VAR;
                        cnt_reg           <= STEP_W'(ROOT_STEPS);
                        state_reg         <= ST_ROOT_VAR;
                    end
                end
                ST_ROOT_VAR: begin
                    if (cnt_reg != '0) begin
                        cmd_reg.root_step <= 1'b1;
                        cnt_reg           <= cnt_reg - 1'b1;
                    end else begin
                        cmd_reg.sd_load <= 1'b1;
                        state_reg       <= ST_PUBLISH;
                    end
                end
                ST_PUBLISH: begin
                    if (status.out_free) begin
                        cmd_reg.out_load <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign cmd      = cmd_reg;

endmodule

`default_nettype wire

### rtl/core/rss_datapath.sv
// ----------------------------------------------------------------------------
// rss_datapath
// Accumulators, bit-serial divider, digit-serial square root and the output
// register of the running sample statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   in_fire,
    input  rss_pkg::kind_t                        in_kind,
    input  wire [rss_pkg::IN_SAMPLE_W-1:0]        in_sample,
    input  rss_pkg::cmd_t                         cmd,
    output rss_pkg::status_t                      status,
    input  wire                                   out_ready,
    output logic                                  out_valid,
    output rss_pkg::result_t                      result
);

    localparam int S           = SAMPLE_BITS;
    localparam int C           = COUNT_BITS;
    localparam int SUM_W       = S + C;
    localparam int SQ_W        = rss_pkg::sq_width(S, C);
    localparam int PROD_W      = 2 * S;
    localparam int MS_W        = 2 * S - 1;
    localparam int RAD_W       = 2 * S;
    localparam int EXT_W       = S + rss_pkg::IN_SAMPLE_W;
    localparam int VAL_W       = rss_pkg::VAL_W;
    localparam int POWER_W     = rss_pkg::POWER_W;
    localparam int COUNT_OUT_W = rss_pkg::COUNT_OUT_W;
    localparam int ROOT_OUT_W  = rss_pkg::ROOT_OUT_W;

    logic signed [SUM_W-1:0] running_sum_reg;
    logic [SQ_W-1:0]         sq_sum_reg;
    logic signed [S-1:0]     smallest_reg;
    logic signed [S-1:0]     largest_reg;
    logic [C-1:0]            count_reg;
    logic                    dropped_reg;
    logic                    sq_pend_reg;
    logic [MS_W-1:0]         square_reg;

    logic [SQ_W-1:0]         dvd_reg;
    logic [C-1:0]            rem_reg;
    logic                    neg_reg;
    logic signed [S-1:0]     mean_reg;
    logic [MS_W-1:0]         ms_reg;
    logic [MS_W-1:0]         msq_reg;
    logic [MS_W-1:0]         var_reg;

    logic [RAD_W-1:0]        rad_reg;
    logic [S-1:0]            root_rem_reg;
    logic [S-1:0]            root_reg;
    logic [S-1:0]            rms_reg;
    logic [S-1:0]            sd_reg;

    logic                    out_valid_reg;
    rss_pkg::result_t        result_reg;

    logic [EXT_W-1:0]        in_ext;
    logic signed [S-1:0]     x_val;
    logic signed [PROD_W-1:0] x_sq;
    logic                    is_clear;
    logic                    is_sample;
    logic                    count_full;
    logic                    take;
    logic [SQ_W:0]           sq_add;
    logic [SQ_W-1:0]         sq_sum_next;
    logic                    count_ge2;

    logic [SUM_W-1:0]        sum_mag;
    logic [C:0]              div_shift;
    logic                    div_ge;
    logic [C:0]              div_diff;
    logic [S-1:0]            q_low;
    logic signed [PROD_W-1:0] msq_prod;

    logic [S+1:0]            trial_rem;
    logic [S+1:0]            trial;
    logic                    root_ge;
    logic [S+1:0]            root_diff;

    assign in_ext     = EXT_W'(in_sample);
    assign x_val      = signed'(in_ext[S-1:0]);
    assign x_sq       = x_val * x_val;
    assign is_clear   = in_fire && (in_kind == rss_pkg::KIND_CLEAR);
    assign is_sample  = in_fire && (in_kind == rss_pkg::KIND_SAMPLE);
    assign count_full = &count_reg;
    assign take       = is_sample && !count_full;
    assign sq_add     = {1'b0, sq_sum_reg} + (SQ_W + 1)'(square_reg);
    assign sq_sum_next = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
    assign count_ge2  = (count_reg > C'(1));

    assign sum_mag   = running_sum_reg[SUM_W-1] ? SUM_W'(~running_sum_reg + 1'b1)
                                                : SUM_W'(running_sum_reg);
    assign div_shift = {rem_reg, dvd_reg[SQ_W-1]};
    assign div_ge    = (div_shift >= {1'b0, count_reg});
    assign div_diff  = div_shift - {1'b0, count_reg};
    assign q_low     = dvd_reg[S-1:0];
    assign msq_prod  = mean_reg * mean_reg;

    assign trial_rem = {root_rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign root_ge   = (trial_rem >= trial);
    assign root_diff = trial_rem - trial;

    // accumulators; a clear overrides a square still in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= '0;
            sq_sum_reg      <= '0;
            smallest_reg    <= '0;
            largest_reg     <= '0;
            count_reg       <= '0;
            dropped_reg     <= 1'b0;
            sq_pend_reg     <= 1'b0;
        end else begin
            if (is_clear) begin
                running_sum_reg <= '0;
                sq_sum_reg      <= '0;
                count_reg       <= '0;
                dropped_reg     <= 1'b0;
                smallest_reg    <= x_val;
                largest_reg     <= x_val;
            end else begin
                if (sq_pend_reg) begin
                    sq_sum_reg <= sq_sum_next;
                end
                if (take) begin
                    running_sum_reg <= running_sum_reg + SUM_W'(x_val);
                    count_reg       <= count_reg + 1'b1;
                    if (x_val > largest_reg) begin
                        largest_reg <= x_val;
                    end
                    if (x_val < smallest_reg) begin
                        smallest_reg <= x_val;
                    end
                end
                if (is_sample && count_full) begin
                    dropped_reg <= 1'b1;
                end
            end
            sq_pend_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        square_reg <= MS_W'(x_sq);
    end

    // divider, root unit and finalize registers
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            dvd_reg <= (cmd.div_sel == rss_pkg::DIV_SUM) ? SQ_W'(sum_mag) : sq_sum_reg;
            rem_reg <= '0;
            neg_reg <= running_sum_reg[SUM_W-1];
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[SQ_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[C-1:0] : div_shift[C-1:0];
        end
        if (cmd.mean_load) begin
            mean_reg <= neg_reg ? (~q_low + 1'b1) : q_low;
        end
        if (cmd.ms_load) begin
            ms_reg <= dvd_reg[MS_W-1:0];
        end
        if (cmd.msq_load) begin
            msq_reg <= msq_prod[MS_W-1:0];
        end
        if (cmd.var_load) begin
            var_reg <= (ms_reg > msq_reg) ? (ms_reg - msq_reg) : '0;
        end
        if (cmd.root_init) begin
            rad_reg      <= RAD_W'((cmd.root_sel == rss_pkg::ROOT_MS) ? ms_reg : var_reg);
            root_rem_reg <= '0;
            root_reg     <= '0;
        end else if (cmd.root_step) begin
            rad_reg      <= {rad_reg[RAD_W-3:0], 2'b00};
            root_rem_reg <= root_ge ? root_diff[S-1:0] : trial_rem[S-1:0];
            root_reg     <= {root_reg[S-2:0], root_ge};
        end
        if (cmd.rms_load) begin
            rms_reg <= root_reg;
        end
        if (cmd.sd_load) begin
            sd_reg <= root_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // zero the derived figures when fewer than two samples are held
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            result_reg.ready_res    <= count_ge2;
            result_reg.saturated    <= dropped_reg;
            result_reg.sample_count <= COUNT_OUT_W'(count_reg);
            result_reg.minimum      <= VAL_W'(smallest_reg);
            result_reg.maximum      <= VAL_W'(largest_reg);
            result_reg.mean         <= count_ge2 ? VAL_W'(mean_reg) : '0;
            result_reg.mean_square  <= count_ge2 ? POWER_W'(ms_reg) : '0;
            result_reg.variance     <= count_ge2 ? POWER_W'(var_reg) : '0;
            result_reg.rms          <= count_ge2 ? ROOT_OUT_W'(rms_reg) : '0;
            result_reg.std_dev      <= count_ge2 ? ROOT_OUT_W'(sd_reg) : '0;
        end
    end

    assign status.count_ge2 = count_ge2;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign result           = result_reg;

endmodule

`default_nettype wire

### test/running_sample_statistics_checker.sv
// ----------------------------------------------------------------------------
// running_sample_statistics_checker
// Watches both stream channels of the running sample statistics block. For
// every clear, sample or finalize word taken on the slave side it updates
// its own copy of the accumulators, and on finalize it works out the whole
// result word. Each result word taken on the master side is compared field
// by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module running_sample_statistics_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [rss_pkg::IN_SAMPLE_W-1:0] s_tdata,
    input  logic [rss_pkg::KIND_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rss_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [rss_pkg::M_TUSER_W-1:0]  m_tuser,
    output int                             mismatches,
    output int                             pending,
    output int                             results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_CAP = 65535;

    longint      acc_sum;
    bit [63:0]   acc_squares;
    longint      lowest;
    longint      highest;
    int unsigned taken;
    bit          dropped;

    rss_pkg::result_t due_results[$];

    assign pending = due_results.size();

    initial begin
        mismatches = 0;
        results_checked = 0;
    end

    function automatic bit [31:0] int_root(input bit [63:0] v);
        bit [31:0] root;
        bit [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = 64'(root | (32'd1 << b));
            if (trial * trial <= v) root = trial[31:0];
        end
        return root;
    endfunction

    function automatic rss_pkg::result_t summarise();
        rss_pkg::result_t r;
        longint    avg;
        bit [63:0] ms;
        bit [63:0] avg_sq;
        bit [63:0] spread;
        r = '0;
        r.saturated = dropped;
        r.sample_count = taken[rss_pkg::COUNT_OUT_W-1:0];
        r.minimum = lowest[rss_pkg::VAL_W-1:0];
        r.maximum = highest[rss_pkg::VAL_W-1:0];
        if (taken >= 2) begin
            avg = acc_sum / longint'(taken);
            ms = acc_squares / 64'(taken);
            avg_sq = 64'(avg * avg);
            spread = (ms > avg_sq) ? ms - avg_sq : 64'd0;
            r.ready_res = 1'b1;
            r.mean = avg[rss_pkg::VAL_W-1:0];
            r.mean_square = ms[rss_pkg::POWER_W-1:0];
            r.variance = spread[rss_pkg::POWER_W-1:0];
            r.rms = rss_pkg::ROOT_OUT_W'(int_root(ms));
            r.std_dev = rss_pkg::ROOT_OUT_W'(int_root(spread));
        end
        return r;
    endfunction

    function automatic rss_pkg::result_t unpack_result(
        input logic [rss_pkg::M_TDATA_W-1:0] d,
        input logic [rss_pkg::M_TUSER_W-1:0] u);
        rss_pkg::result_t r;
        r.ready_res    = u[0];
        r.saturated    = u[1];
        r.sample_count = d[15:0];
        r.minimum      = d[31:16];
        r.maximum      = d[47:32];
        r.mean         = d[63:48];
        r.mean_square  = d[94:64];
        r.variance     = d[125:95];
        r.rms          = d[141:126];
        r.std_dev      = d[157:142];
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        mismatches++;
        $display("%0t: result %0d %s: got %0h, want %0h",
                 $realtime, results_checked, what, got, want);
    endtask

    task automatic compare_result(input rss_pkg::result_t got,
                                  input rss_pkg::result_t want);
        if (got.ready_res !== want.ready_res)
            report("ready_res", 64'(got.ready_res), 64'(want.ready_res));
        if (got.saturated !== want.saturated)
            report("saturated", 64'(got.saturated), 64'(want.saturated));
        if (got.sample_count !== want.sample_count)
            report("sample_count", 64'(got.sample_count), 64'(want.sample_count));
        if (got.minimum !== want.minimum)
            report("minimum", 64'(got.minimum), 64'(want.minimum));
        if (got.maximum !== want.maximum)
            report("maximum", 64'(got.maximum), 64'(want.maximum));
        if (got.mean !== want.mean)
            report("mean", 64'(got.mean), 64'(want.mean));
        if (got.mean_square !== want.mean_square)
            report("mean_square", 64'(got.mean_square), 64'(want.mean_square));
        if (got.variance !== want.variance)
            report("variance", 64'(got.variance), 64'(want.variance));
        if (got.rms !== want.rms)
            report("rms", 64'(got.rms), 64'(want.rms));
        if (got.std_dev !== want.std_dev)
            report("std_dev", 64'(got.std_dev), 64'(want.std_dev));
    endtask

    task automatic absorb_word(input rss_pkg::kind_t k,
                               input logic [rss_pkg::IN_SAMPLE_W-1:0] raw);
        longint x;
        x = longint'($signed(raw));
        case (k)
            rss_pkg::KIND_CLEAR: begin
                lowest = x;
                highest = x;
                acc_sum = 0;
                acc_squares = '0;
                taken = 0;
                dropped = 1'b0;
            end
            rss_pkg::KIND_SAMPLE: begin
                if (taken >= COUNT_CAP) begin
                    dropped = 1'b1;
                end else begin
                    acc_sum += x;
                    acc_squares += 64'(x * x);
                    if (x > highest) highest = x;
                    if (x < lowest) lowest = x;
                    taken++;
                end
            end
            rss_pkg::KIND_FINAL: begin
                due_results.push_back(summarise());
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            acc_sum <= 0;
            acc_squares <= '0;
            lowest <= 0;
            highest <= 0;
            taken <= 0;
            dropped <= 1'b0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report("unexpected word", m_tdata[63:0], 64'd0);
                end else begin
                    compare_result(unpack_result(m_tdata, m_tuser),
                                   due_results.pop_front());
                end
                results_checked++;
            end
            if (s_tvalid && s_tready) absorb_word(rss_pkg::kind_t'(s_tuser), s_tdata);
        end
    end

endmodule

### test/running_sample_statistics_test.sv
// ----------------------------------------------------------------------------
// running_sample_statistics_test
// Stimulus for the running sample statistics block: a directed pass over
// empty, single-sample and extreme-valued sets, repeated finalize and the
// unused kind; a stretch with no idling on either side; then random clear,
// sample and finalize sequences with noise. Both channels idle at random.
// A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module running_sample_statistics_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam rss_pkg::kind_t KIND_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 760;
    localparam int STEADY_WORDS = 60;
    localparam int DRAIN_CYCLES = 200;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rss_pkg::IN_SAMPLE_W-1:0] s_tdata = '0;
    logic [rss_pkg::KIND_W-1:0]      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rss_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [rss_pkg::M_TUSER_W-1:0]   m_tuser;

    int mismatches;
    int pending;
    int results_checked;
    int words_sent = 0;
    bit steady = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    running_sample_statistics dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    running_sample_statistics_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 12);
    end

    task automatic offer_word(input rss_pkg::kind_t k,
                              input logic [rss_pkg::IN_SAMPLE_W-1:0] x);
        while (!steady && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (k != KIND_UNUSED) words_sent++;
    endtask

    function automatic logic [rss_pkg::IN_SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 16) - 8);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'h8000 + 16'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic run_batch();
        int n;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
                offer_word(rss_pkg::kind_t'($urandom_range(0, 3)), 16'($urandom));
        end else begin
            if ($urandom_range(0, 4) != 0) offer_word(rss_pkg::KIND_CLEAR, pick_sample());
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 24);
            repeat (n) offer_word(rss_pkg::KIND_SAMPLE, pick_sample());
            offer_word(rss_pkg::KIND_FINAL, pick_sample());
            if ($urandom_range(0, 3) == 0) offer_word(rss_pkg::KIND_FINAL, 16'($urandom));
        end
    endtask

    initial begin
        int start_count;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_word(rss_pkg::KIND_FINAL, 16'h0000);
        offer_word(rss_pkg::KIND_CLEAR, 16'h7fff);
        offer_word(rss_pkg::KIND_FINAL, 16'h1234);
        offer_word(rss_pkg::KIND_SAMPLE, 16'h8000);
        offer_word(rss_pkg::KIND_FINAL, 16'h0000);
        offer_word(rss_pkg::KIND_SAMPLE, 16'h7fff);
        offer_word(rss_pkg::KIND_FINAL, 16'h0000);
        offer_word(rss_pkg::KIND_FINAL, 16'hffff);
        offer_word(KIND_UNUSED, 16'h5555);
        offer_word(rss_pkg::KIND_CLEAR, 16'h8000);
        repeat (3) offer_word(rss_pkg::KIND_SAMPLE, 16'h8000);
        offer_word(rss_pkg::KIND_FINAL, 16'h0000);
        offer_word(rss_pkg::KIND_CLEAR, 16'h0000);
        offer_word(rss_pkg::KIND_SAMPLE, 16'hffff);
        offer_word(rss_pkg::KIND_SAMPLE, 16'hfffe);
        offer_word(rss_pkg::KIND_FINAL, 16'h0000);
        offer_word(KIND_UNUSED, 16'haaaa);
        offer_word(rss_pkg::KIND_SAMPLE, 16'h7fff);
        offer_word(rss_pkg::KIND_SAMPLE, 16'h8000);
        offer_word(rss_pkg::KIND_FINAL, 16'h0000);

        // run with no gaps on either side
        steady = 1'b1;
        offer_word(rss_pkg::KIND_CLEAR, pick_sample());
        repeat (STEADY_WORDS) offer_word(rss_pkg::KIND_SAMPLE, pick_sample());
        offer_word(rss_pkg::KIND_FINAL, 16'h0000);
        offer_word(rss_pkg::KIND_SAMPLE, 16'h7fff);
        offer_word(rss_pkg::KIND_FINAL, 16'h0000);
        offer_word(rss_pkg::KIND_CLEAR, 16'h0001);
        offer_word(rss_pkg::KIND_FINAL, 16'h0000);
        steady = 1'b0;

        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS)
            run_batch();
        s_tvalid <= 1'b0;

        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words, among them a %0d-sample run with no idling.",
                 words_sent, STEADY_WORDS);
        $display("Checked %0d result words, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
